>>> design/fwps_pkg.sv
package fwps_pkg;

  typedef struct packed {
    logic signed [15:0] warp_x;
    logic signed [15:0] warp_y;
    logic [31:0]        frame_time_ms;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  localparam logic [9:0] CG_RESET = 10'd563;

  // phase rates in micro-degrees per millisecond
  localparam logic [15:0] RATE [2] = '{16'd52589, 16'd45321};

  // 2^21 = 134 * 15625 + 3402, used to fold the phase dividend
  localparam logic [11:0] REM21 = 12'd3402;
  localparam logic [7:0]  QUO21 = 8'd134;

  // ceil(2^41 / 15625), ceil(2^37 / 360), ceil(2^27 / 360)
  localparam logic [27:0] RECIP_Z  = 28'd140737489;
  localparam logic [28:0] RECIP_P  = 29'd381774871;
  localparam logic [18:0] RECIP_A  = 19'd372828;
  // 256 turns, keeps every angle positive before the wrap
  localparam logic [17:0] ANG_BIAS = 18'd92160;

  localparam logic [14:0] QSINE [0:90] = '{
    15'd0, 15'd572, 15'd1144, 15'd1715, 15'd2286, 15'd2856, 15'd3425, 15'd3993,
    15'd4560, 15'd5126, 15'd5690, 15'd6252, 15'd6813, 15'd7371, 15'd7927, 15'd8481,
    15'd9032, 15'd9580, 15'd10126, 15'd10668, 15'd11207, 15'd11743, 15'd12275,
    15'd12803, 15'd13328, 15'd13848, 15'd14364, 15'd14876, 15'd15383, 15'd15886,
    15'd16383, 15'd16876, 15'd17364, 15'd17846, 15'd18323, 15'd18794, 15'd19260,
    15'd19720, 15'd20173, 15'd20621, 15'd21062, 15'd21497, 15'd21925, 15'd22347,
    15'd22762, 15'd23170, 15'd23571, 15'd23964, 15'd24351, 15'd24730, 15'd25101,
    15'd25465, 15'd25821, 15'd26169, 15'd26509, 15'd26841, 15'd27165, 15'd27481,
    15'd27788, 15'd28087, 15'd28377, 15'd28659, 15'd28932, 15'd29196, 15'd29451,
    15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591, 15'd30791, 15'd30982,
    15'd31163, 15'd31335, 15'd31498, 15'd31650, 15'd31794, 15'd31927, 15'd32051,
    15'd32165, 15'd32269, 15'd32364, 15'd32448, 15'd32523, 15'd32587, 15'd32642,
    15'd32687, 15'd32722, 15'd32747, 15'd32762, 15'd32767
  };

endpackage

>>> design/flow_warp_palette_shader.sv
// Flow-warp palette shader: takes one pixel request per clock while out_stall is low
// (warped x/y in Q8.8 and the frame time in ms) and returns its saturated RGB bytes.
// Fully pipelined, one request per cycle sustained unless the output stalls; the stages
// are the phase divider (7 stages), twelve stages per flow round, the square root (5 stages)
// and the palette (4 stages). Stalls freeze only the stages that are full, so bubbles are
// squeezed out. contrast_gain must only be written while the pipeline is empty.
module flow_warp_palette_shader #(
  parameter int FLOW_ITERATIONS = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fwps_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fwps_pkg::out_t  out_data,
  input  logic            cfg_wr_en,
  input  logic [9:0]      cfg_wr_data
);

  localparam int IT_N   = 12 * FLOW_ITERATIONS;
  localparam int FR_N   = 6;
  localparam int IT_OFF = FR_N;
  localparam int BK_OFF = IT_OFF + IT_N + 1;
  localparam int BK_N   = 8;
  localparam int NS     = BK_OFF + BK_N + 1;

  // front stage kinds
  localparam int FS_MUL   = 1;
  localparam int FS_FOLD1 = 2;
  localparam int FS_FOLD2 = 3;
  localparam int FS_RECIP = 4;
  localparam int FS_MOD   = 5;

  // flow round stage kinds
  localparam int ST_MAXDEG  = 0;
  localparam int ST_WRAP0   = 1;
  localparam int ST_SINE0   = 2;
  localparam int ST_VADD    = 3;
  localparam int ST_PHASE   = 4;
  localparam int ST_WRAP1   = 5;
  localparam int ST_SINE1   = 6;
  localparam int ST_UADD    = 7;
  localparam int ST_FLOWDEG = 8;
  localparam int ST_WRAP2   = 9;
  localparam int ST_SINE2   = 10;
  localparam int ST_FLOW    = 11;

  // back stage kinds
  localparam int BS_PAINT  = 5;
  localparam int BS_WEIGHT = 6;
  localparam int BS_LIGHT  = 7;

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic [31:0]        t;
    logic [1:0][20:0]   xh;
    logic [1:0][20:0]   xl;
    logic [1:0][33:0]   y;
    logic [1:0][28:0]   q;
    logic [1:0][23:0]   z;
    logic [1:0][9:0]    qz;
    logic [1:0][27:0]   ph;
    logic [1:0][19:0]   qp;
  } fr_t;

  typedef struct packed {
    logic signed [19:0] ux;
    logic signed [19:0] uy;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic [8:0]         ph1;
    logic [8:0]         ph2;
    logic signed [17:0] arg_a;
    logic signed [17:0] arg_b;
    logic [9:0]         quo_a;
    logic [9:0]         quo_b;
    logic signed [8:0]  sin_a;
    logic signed [8:0]  sin_b;
  } it_t;

  typedef struct packed {
    logic [31:0] v;
    logic [31:0] r;
    logic [9:0]  paint;
    logic [8:0]  w1;
    logic [8:0]  w2;
    logic [8:0]  w3;
    logic [7:0]  light;
  } bk_t;

  logic [9:0]     cg_r;
  logic [NS-1:0]  v_r;
  logic [NS-1:0]  ld;
  fr_t            fr_r   [FR_N];
  fr_t            fr_nxt [FR_N];
  it_t            it_r   [IT_N+1];
  it_t            it_nxt [IT_N+1];
  bk_t            bk_r   [BK_N];
  bk_t            bk_nxt [BK_N];
  fwps_pkg::out_t out_r;
  fwps_pkg::out_t out_nxt;

  function automatic logic signed [31:0] to_deg(input logic signed [31:0] q);
    return (q * 32'sd57) >>> 8;
  endfunction

  function automatic logic signed [31:0] div256t(input logic signed [31:0] x);
    return (x + (x[31] ? 32'sd255 : 32'sd0)) >>> 8;
  endfunction

  function automatic logic signed [31:0] div2t(input logic signed [31:0] x);
    return (x + (x[31] ? 32'sd1 : 32'sd0)) >>> 1;
  endfunction

  function automatic logic [17:0] ang_pos(input logic signed [17:0] arg);
    return 18'(arg) + fwps_pkg::ANG_BIAS;
  endfunction

  function automatic logic [9:0] wrap_q(input logic signed [17:0] arg);
    logic [36:0] p;
    p = 37'(ang_pos(arg)) * 37'(fwps_pkg::RECIP_A);
    return p[36:27];
  endfunction

  function automatic logic signed [8:0] sine_at(input logic signed [17:0] arg,
                                                input logic [9:0] q);
    logic [17:0] r;
    logic [8:0]  a;
    logic [6:0]  idx;
    logic        neg;
    logic [15:0] s;
    logic [8:0]  mag;
    r   = ang_pos(arg) - 18'(q) * 18'd360;
    a   = r[8:0];
    neg = 1'b0;
    if (a < 9'd90) begin
      idx = a[6:0];
    end else if (a < 9'd180) begin
      idx = 7'(9'd180 - a);
    end else if (a < 9'd270) begin
      idx = 7'(a - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - a);
      neg = 1'b1;
    end
    s = 16'(fwps_pkg::QSINE[idx]);
    // floor shift on the negative half rounds the magnitude up
    mag = neg ? 9'((s + 16'd127) >> 7) : 9'(s >> 7);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic fr_t front_step(input fr_t s, input int kind);
    fr_t         n;
    logic [47:0] p;
    logic [25:0] zw;
    logic [51:0] pz;
    logic [56:0] pp;
    n = s;
    for (int j = 0; j < 2; j++) begin
      case (kind)
        FS_MUL: begin
          p = 48'(s.t) * 48'(fwps_pkg::RATE[1'(j)]);
          // drop the factor of 64 in one million
          n.xh[1'(j)] = p[47:27];
          n.xl[1'(j)] = p[26:6];
        end
        FS_FOLD1: begin
          n.y[1'(j)] = 34'(s.xh[1'(j)]) * 34'(fwps_pkg::REM21) + 34'(s.xl[1'(j)]);
          n.q[1'(j)] = 29'(s.xh[1'(j)]) * 29'(fwps_pkg::QUO21);
        end
        FS_FOLD2: begin
          zw = 26'(s.y[1'(j)][33:21]) * 26'(fwps_pkg::REM21) + 26'(s.y[1'(j)][20:0]);
          n.z[1'(j)] = zw[23:0];
          n.q[1'(j)] = s.q[1'(j)] + 29'(s.y[1'(j)][33:21]) * 29'(fwps_pkg::QUO21);
        end
        FS_RECIP: begin
          pz = 52'(s.z[1'(j)]) * 52'(fwps_pkg::RECIP_Z);
          n.qz[1'(j)] = pz[50:41];
        end
        FS_MOD: begin
          n.ph[1'(j)] = 28'(s.q[1'(j)] + 29'(s.qz[1'(j)]));
          pp = 57'(n.ph[1'(j)]) * 57'(fwps_pkg::RECIP_P);
          n.qp[1'(j)] = pp[56:37];
        end
        default: ;
      endcase
    end
    return n;
  endfunction

  function automatic it_t front_finish(input fr_t s);
    it_t         n;
    logic [27:0] m1;
    logic [27:0] m2;
    n     = '0;
    m1    = s.ph[0] - 28'(s.qp[0]) * 28'd360;
    m2    = s.ph[1] - 28'(s.qp[1]) * 28'd360;
    n.ph1 = m1[8:0];
    n.ph2 = m2[8:0];
    n.ux  = 20'(s.ux);
    n.uy  = 20'(s.uy);
    n.vx  = 20'(s.ux) + 20'(s.uy);
    n.vy  = 20'(s.ux) + 20'(s.uy);
    return n;
  endfunction

  function automatic it_t iter_step(input it_t s, input int kind);
    it_t               n;
    logic signed [19:0] m;
    logic signed [19:0] fl;
    n = s;
    case (kind)
      ST_MAXDEG: begin
        m       = (s.ux > s.uy) ? s.ux : s.uy;
        n.arg_a = 18'(to_deg(32'(m)));
      end
      ST_WRAP0, ST_WRAP1, ST_WRAP2: begin
        n.quo_a = wrap_q(s.arg_a);
        n.quo_b = wrap_q(s.arg_b);
      end
      ST_SINE0, ST_SINE1, ST_SINE2: begin
        n.sin_a = sine_at(s.arg_a, s.quo_a);
        n.sin_b = sine_at(s.arg_b, s.quo_b);
      end
      ST_VADD: begin
        n.vx = s.vx + 20'(s.sin_a) + s.ux;
        n.vy = s.vy + 20'(s.sin_a) + s.uy;
      end
      ST_PHASE: begin
        // cosine taken as sine of angle plus a quarter turn
        n.arg_a = 18'(32'sd293 + div256t(to_deg(32'(s.vy)) * 32'sd90)
                      + $signed(32'(s.ph1)) + 32'sd90);
        n.arg_b = 18'(to_deg(32'(s.vx)) - $signed(32'(s.ph2)));
      end
      ST_UADD: begin
        n.ux = s.ux + 20'(div2t(32'(s.sin_a)));
        n.uy = s.uy + 20'(div2t(32'(s.sin_b)));
      end
      ST_FLOWDEG: begin
        n.arg_a = 18'(to_deg(32'(s.ux) + 32'(s.uy)) + 32'sd90);
        n.arg_b = 18'(to_deg(div256t(32'(s.ux) * 32'sd182) - 32'(s.uy)));
      end
      ST_FLOW: begin
        fl   = 20'(s.sin_a) - 20'(s.sin_b);
        n.ux = s.ux - fl;
        n.uy = s.uy - fl;
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic bk_t back_square(input it_t s);
    bk_t         n;
    logic [19:0] ax;
    logic [19:0] ay;
    logic [39:0] sx;
    logic [39:0] sy;
    n  = '0;
    ax = s.ux[19] ? 20'(-s.ux) : 20'(s.ux);
    ay = s.uy[19] ? 20'(-s.uy) : 20'(s.uy);
    sx = ax * ax;
    sy = ay * ay;
    n.v = sx[31:0] + sy[31:0];
    return n;
  endfunction

  function automatic bk_t back_step(input bk_t s, input int kind, input logic [9:0] cg);
    bk_t         n;
    logic [31:0] b;
    logic [15:0] len;
    logic [11:0] p1;
    logic [21:0] p2;
    logic [8:0]  d1;
    logic [19:0] t1;
    logic [19:0] t2;
    logic [10:0] e1;
    logic [10:0] e2;
    logic [8:0]  l1;
    logic [8:0]  l2;
    logic [16:0] lsum;
    n = s;
    case (kind)
      BS_PAINT: begin
        len = s.r[15:0];
        p1  = 12'((20'(len) * 20'd9) >> 8);
        p2  = (22'(p1) * 22'(cg)) >> 8;
        n.paint = (p2 > 22'd512) ? 10'd512 : p2[9:0];
      end
      BS_WEIGHT: begin
        d1 = (s.paint >= 10'd256) ? 9'(s.paint - 10'd256) : 9'(10'd256 - s.paint);
        t1 = (20'(cg) * 20'(d1)) >> 8;
        t2 = (20'(cg) * 20'(s.paint)) >> 8;
        n.w1 = (t1 >= 20'd256) ? 9'd0 : 9'(20'd256 - t1);
        n.w2 = (t2 >= 20'd256) ? 9'd0 : 9'(20'd256 - t2);
      end
      BS_LIGHT: begin
        n.w3 = (10'(s.w1) + 10'(s.w2) >= 10'd256) ? 9'd0
             : 9'(10'd256 - 10'(s.w1) - 10'(s.w2));
        e1 = 11'(s.w1) * 11'd5;
        e2 = 11'(s.w2) * 11'd5;
        l1 = (e1 > 11'd1024) ? 9'(e1 - 11'd1024) : 9'd0;
        l2 = (e2 > 11'd1024) ? 9'(e2 - 11'd1024) : 9'd0;
        lsum = 17'(l1) * 17'd51 + 17'(l2) * 17'd102;
        n.light = 8'(lsum >> 8);
      end
      default: begin
        // square root, four result bits per stage
        for (int i = 0; i < 4; i++) begin
          b = 32'd1 << (30 - 2 * ((kind - 1) * 4 + i));
          if (n.v >= n.r + b) begin
            n.v = n.v - (n.r + b);
            n.r = (n.r >> 1) + b;
          end else begin
            n.r = n.r >> 1;
          end
        end
      end
    endcase
    return n;
  endfunction

  function automatic logic [7:0] sat8(input logic [31:0] v);
    return (v > 32'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic fwps_pkg::out_t shade(input bk_t s);
    fwps_pkg::out_t o;
    logic [31:0]    lt;
    logic [31:0]    w1;
    logic [31:0]    w2;
    logic [31:0]    w3;
    w1 = 32'(s.w1);
    w2 = 32'(s.w2);
    w3 = 32'(s.w3);
    lt = (32'(s.light) * 32'd255) >> 8;
    o.red   = sat8(32'd19 + ((32'd234 * (32'd222 * w1 + 32'd22 * w3)) >> 16) + lt);
    o.green = sat8(32'd6 + ((32'd234 * (32'd68 * w1 + 32'd107 * w2 + 32'd35 * w3)) >> 16)
                   + lt);
    o.blue  = sat8(32'd5 + ((32'd234 * (32'd59 * w1 + 32'd180 * w2 + 32'd37 * w3)) >> 16)
                   + lt);
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cg_r <= fwps_pkg::CG_RESET;
    end else if (cfg_wr_en) begin
      cg_r <= cfg_wr_data;
    end
  end

  // a stage takes new data when it is empty or its successor moves on
  always_comb begin
    ld[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_stall = !ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    fr_nxt[0]    = '0;
    fr_nxt[0].ux = in_data.warp_x;
    fr_nxt[0].uy = in_data.warp_y;
    fr_nxt[0].t  = in_data.frame_time_ms;
  end

  for (genvar g = 1; g < FR_N; g++) begin : g_front
    assign fr_nxt[g] = front_step(fr_r[g-1], g);
  end

  for (genvar g = 0; g < FR_N; g++) begin : g_front_reg
    always_ff @(posedge clk) begin
      if (ld[g]) begin
        fr_r[g] <= fr_nxt[g];
      end
    end
  end

  assign it_nxt[0] = front_finish(fr_r[FR_N-1]);

  for (genvar g = 1; g <= IT_N; g++) begin : g_iter
    localparam int Kind = (g - 1) % 12;
    assign it_nxt[g] = iter_step(it_r[g-1], Kind);
  end

  for (genvar g = 0; g <= IT_N; g++) begin : g_iter_reg
    always_ff @(posedge clk) begin
      if (ld[IT_OFF+g]) begin
        it_r[g] <= it_nxt[g];
      end
    end
  end

  assign bk_nxt[0] = back_square(it_r[IT_N]);

  for (genvar g = 1; g < BK_N; g++) begin : g_back
    assign bk_nxt[g] = back_step(bk_r[g-1], g, cg_r);
  end

  for (genvar g = 0; g < BK_N; g++) begin : g_back_reg
    always_ff @(posedge clk) begin
      if (ld[BK_OFF+g]) begin
        bk_r[g] <= bk_nxt[g];
      end
    end
  end

  assign out_nxt = shade(bk_r[BK_N-1]);

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted request did not reach the entry stage");

  a_empty_entry_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> !in_stall)
    else $error("empty entry stage refused a request");

  a_phase_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[IT_OFF] |-> (it_r[0].ph1 < 9'd360 && it_r[0].ph2 < 9'd360))
    else $error("phase offset not reduced below a full turn");

  a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[BK_OFF+4] |-> (bk_r[4].r[31:16] == 16'd0))
    else $error("square root wider than 16 bits");
`endif

endmodule

>>> sim/shade_checker.sv
module shade_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  fwps_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  fwps_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic [9:0]     cfg_wr_data,
  output int             fail_count,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLOW_ROUNDS = 2;
  localparam int Q1 = 256;

  logic [9:0]     gain;
  fwps_pkg::out_t colour_q[$];

  function automatic int deg_of(int q);
    return (q * 57) >>> 8;
  endfunction

  function automatic int sin8(int deg);
    int a;
    int s;
    a = deg % 360;
    if (a < 0) a += 360;
    if (a < 90) s = int'(fwps_pkg::QSINE[a]);
    else if (a < 180) s = int'(fwps_pkg::QSINE[180 - a]);
    else if (a < 270) s = -int'(fwps_pkg::QSINE[a - 180]);
    else s = -int'(fwps_pkg::QSINE[360 - a]);
    return s >>> 7;
  endfunction

  function automatic int unsigned root_of(int unsigned v);
    int unsigned r;
    int unsigned b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic fwps_pkg::out_t shade_pixel(fwps_pkg::in_t px, logic [9:0] cg_bits);
    longint unsigned t;
    int ux, uy, vx, vy, ph1, ph2, cg, m, sm, a1, a2, sd, dd, fl;
    int ax, ay, len, paint, d1, w1, w2, w3, l1, l2, light, lt, r, g, b;
    int unsigned sq;
    fwps_pkg::out_t o;
    ux = px.warp_x;
    uy = px.warp_y;
    t = px.frame_time_ms;
    ph1 = int'((t * 64'd52589) / 64'd1000000);
    ph2 = int'((t * 64'd45321) / 64'd1000000);
    cg = int'(cg_bits);
    vx = ux + uy;
    vy = ux + uy;
    for (int i = 0; i < FLOW_ROUNDS; i++) begin
      m = (ux > uy) ? ux : uy;
      sm = sin8(deg_of(m));
      vx += sm + ux;
      vy += sm + uy;
      a1 = 293 + (deg_of(vy) * 90) / Q1 + ph1;
      a2 = deg_of(vx) - ph2;
      ux += sin8(a1 + 90) / 2;
      uy += sin8(a2) / 2;
      sd = deg_of(ux + uy);
      dd = deg_of((ux * 182) / Q1 - uy);
      fl = sin8(sd + 90) - sin8(dd);
      ux -= fl;
      uy -= fl;
    end
    ax = (ux < 0) ? -ux : ux;
    ay = (uy < 0) ? -uy : uy;
    sq = int'(ax) * int'(ax) + int'(ay) * int'(ay);
    len = int'(root_of(sq));
    paint = (len * 9) / Q1;
    paint = (paint * cg) / Q1;
    if (paint > 2 * Q1) paint = 2 * Q1;
    d1 = Q1 - paint;
    if (d1 < 0) d1 = -d1;
    w1 = Q1 - (cg * d1) / Q1;
    if (w1 < 0) w1 = 0;
    if (w1 > Q1) w1 = Q1;
    w2 = Q1 - (cg * paint) / Q1;
    if (w2 < 0) w2 = 0;
    if (w2 > Q1) w2 = Q1;
    w3 = Q1 - w1 - w2;
    if (w3 < 0) w3 = 0;
    l1 = w1 * 5 - 4 * Q1;
    if (l1 < 0) l1 = 0;
    l2 = w2 * 5 - 4 * Q1;
    if (l2 < 0) l2 = 0;
    light = (l1 * 51 + l2 * 102) / Q1;
    lt = (light * 255) / Q1;
    r = 19 + (234 * (222 * w1 + 22 * w3) / Q1) / Q1 + lt;
    g = 6 + (234 * (68 * w1 + 107 * w2 + 35 * w3) / Q1) / Q1 + lt;
    b = 5 + (234 * (59 * w1 + 180 * w2 + 37 * w3) / Q1) / Q1 + lt;
    o.red = clamp8(r);
    o.green = clamp8(g);
    o.blue = clamp8(b);
    return o;
  endfunction

  always @(posedge clk) begin
    fwps_pkg::out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      gain <= fwps_pkg::CG_RESET;
      fail_count <= 0;
      colour_q.delete();
    end else begin
      if (cfg_wr_en) gain <= cfg_wr_data;
      if (in_valid && !in_stall) colour_q.push_back(shade_pixel(in_data, gain));
      if (out_valid && !out_stall) begin
        if (colour_q.size() == 0) begin
          $error("result with no request outstanding: %h", out_data);
          errs = errs + 1;
        end else begin
          want = colour_q.pop_front();
          if (want.red !== out_data.red) begin
            $error("red: expected %0d, got %0d", want.red, out_data.red);
            errs = errs + 1;
          end
          if (want.green !== out_data.green) begin
            $error("green: expected %0d, got %0d", want.green, out_data.green);
            errs = errs + 1;
          end
          if (want.blue !== out_data.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_data.blue);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending = colour_q.size();
  end
endmodule

>>> sim/flow_warp_palette_shader_test.sv
module flow_warp_palette_shader_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;
  localparam int STALL_LIMIT = 5000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  fwps_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  fwps_pkg::out_t out_data;
  logic           cfg_wr_en = 1'b0;
  logic [9:0]     cfg_wr_data = '0;
  int             fail_count;
  int             pending;
  int             quiet_cycles = 0;
  int             stall_left = 0;
  bit             calm = 0;

  always #5 clk = ~clk;

  flow_warp_palette_shader DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  shade_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // receiver back-pressure, random runs of stall or flow
  always @(posedge clk) begin
    if (stall_left == 0) begin
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_left <= gap_len() + 1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("flow_warp_palette_shader verification failed");
      $finish;
    end
  end

  task automatic send_pixel(logic [15:0] x, logic [15:0] y, logic [31:0] t);
    int n;
    bit took;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{warp_x: x, warp_y: y, frame_time_ms: t};
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_gain(logic [9:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_pixels(int count);
    logic [15:0] x, y;
    logic [31:0] t;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1: begin
          x = 16'($signed($urandom_range(0, 1023)) - 512);
          y = 16'($signed($urandom_range(0, 1023)) - 512);
        end
        2: begin x = 16'($urandom_range(0, 4095)); y = 16'($urandom); end
        default: begin x = 16'($urandom); y = 16'($signed($urandom_range(0, 255)) - 128); end
      endcase
      case ($urandom_range(0, 2))
        0: t = $urandom;
        1: t = $urandom_range(0, 100000);
        default: t = 32'hFFFF_FFFF - $urandom_range(0, 1000000);
      endcase
      send_pixel(x, y, t);
    end
    calm = 0;
  endtask

  localparam logic [15:0] EDGE_XY [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                          16'h0100, 16'hFF00};

  initial begin
    logic [9:0] gains [4];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of coordinates and time at the reset gain
    for (int i = 0; i < 6; i++) begin
      send_pixel(EDGE_XY[i], EDGE_XY[5 - i], 32'd0);
      send_pixel(EDGE_XY[i], EDGE_XY[i], 32'hFFFF_FFFF);
    end
    send_pixel(16'h8000, 16'h8000, 32'd19);
    send_pixel(16'h7FFF, 16'h7FFF, 32'd1000000);
    send_pixel(16'h0000, 16'h0000, 32'h8000_0000);
    random_pixels(200);
    drain();

    gains = '{10'd0, 10'd1023, 10'd256, 10'($urandom_range(0, 1023))};
    for (int p = 0; p < 4; p++) begin
      set_gain(gains[p]);
      send_pixel(16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
      send_pixel(16'h0000, 16'h0000, 32'd0);
      random_pixels(250);
      drain();
    end

    if (fail_count == 0) begin
      $display("flow_warp_palette_shader verification clean");
    end else begin
      $display("flow_warp_palette_shader verification failed");
    end
    $finish;
  end
endmodule

>>> flow_warp_palette_shader.f
design/fwps_pkg.sv
design/flow_warp_palette_shader.sv
sim/shade_checker.sv
sim/flow_warp_palette_shader_test.sv
